/* sv/bbc_pkg.sv */
// shared constants for the bracket balance checker
package bbc_pkg;

    localparam int COUNT_BITS = 16;

    localparam int CHAR_BITS   = 8;
    localparam int STATUS_BITS = 4;

    typedef logic [CHAR_BITS-1:0]   char_t;
    typedef logic [STATUS_BITS-1:0] status_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    localparam count_t COUNT_MAX = '1;

    localparam status_t ST_OK          = 4'd0;
    localparam status_t ST_EXTRA_BRACE = 4'd1;
    localparam status_t ST_EXTRA_PAREN = 4'd2;
    localparam status_t ST_EXTRA_BRACK = 4'd3;
    localparam status_t ST_OPEN_CMT    = 4'd4;
    localparam status_t ST_OPEN_BRACE  = 4'd5;
    localparam status_t ST_OPEN_PAREN  = 4'd6;
    localparam status_t ST_OPEN_BRACK  = 4'd7;
    localparam status_t ST_OVERFLOW    = 4'd8;

    localparam char_t CH_LBRACE    = 8'h7B;
    localparam char_t CH_RBRACE    = 8'h7D;
    localparam char_t CH_LPAREN    = 8'h28;
    localparam char_t CH_RPAREN    = 8'h29;
    localparam char_t CH_LBRACK    = 8'h5B;
    localparam char_t CH_RBRACK    = 8'h5D;
    localparam char_t CH_SLASH     = 8'h2F;
    localparam char_t CH_STAR      = 8'h2A;
    localparam char_t CH_DQUOTE    = 8'h22;
    localparam char_t CH_SQUOTE    = 8'h27;
    localparam char_t CH_BACKSLASH = 8'h5C;
    localparam char_t CH_NEWLINE   = 8'h0A;

endpackage

/* sv/bbc_if.sv */
// valid/ready channels for characters in and verdicts out
interface bbc_char_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           char_code;
    logic                 is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface bbc_result_if;
    logic                 valid;
    logic                 ready;
    logic [3:0]           status;
    logic                 final_res;

    modport source (output valid, output status, output final_res, input ready);
    modport sink   (input valid, input status, input final_res, output ready);
endinterface

/* sv/bracket_balance_checker_unit.sv */
// bracket balance checker: lexer modes, nesting counts and verdict
//
// req carries one byte of source text per transfer, with is_last on the
// final byte. rsp returns exactly one result per byte: status is the error
// latched so far with final_res low, and on the last byte the verdict
// (latched error, open block comment, or first open brace/paren/bracket)
// with final_res high. comments and quoted literals are skipped.
// a byte lands in an input register, is processed by the mode and count
// update logic and its result sits in the output register, which drives
// rsp.valid. one byte per cycle is sustained while rsp is not stalled.
// when rsp is stalled the output register holds and one more byte waits in
// the input register; req.ready then drops until rsp moves again.
// reset (rst_n low) empties both registers and puts the lexer in normal
// code with all counts and the error at zero. after the last byte all
// state returns to that same condition on its own.
module bracket_balance_checker_unit (
    input  logic           clk,
    input  logic           rst_n,
    bbc_char_if.sink       req,
    bbc_result_if.source   rsp
);
    import bbc_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL     = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_LINE       = 3'd2,
        MODE_BLOCK      = 3'd3,
        MODE_BLOCK_STAR = 3'd4,
        MODE_QUOTE      = 3'd5,
        MODE_QUOTE_ESC  = 3'd6
    } mode_t;

    // input register
    logic    in_valid_reg;
    char_t   in_char_reg;
    logic    in_last_reg;

    // output register
    logic    out_valid_reg;
    status_t out_status_reg;
    logic    out_final_reg;

    // lexer and count state
    mode_t   mode_reg,  mode_next;
    logic    qkind_reg, qkind_next;
    count_t  brace_reg, brace_next;
    count_t  paren_reg, paren_next;
    count_t  brack_reg, brack_next;
    status_t err_reg,   err_next;
    status_t status_next;

    logic    advance;
    logic    process;
    logic    code_byte;

    assign advance   = !out_valid_reg || rsp.ready;
    assign process   = in_valid_reg && advance;
    assign req.ready = !in_valid_reg || advance;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.final_res = out_final_reg;

    always_comb
    begin
        mode_next   = mode_reg;
        qkind_next  = qkind_reg;
        brace_next  = brace_reg;
        paren_next  = paren_reg;
        brack_next  = brack_reg;
        err_next    = err_reg;
        code_byte   = 1'b0;
        status_next = ST_OK;

        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (in_char_reg == CH_SLASH)
                    mode_next = MODE_LINE;
                else if (in_char_reg == CH_STAR)
                    mode_next = MODE_BLOCK;
                else
                    code_byte = 1'b1;
            end
            MODE_LINE:
            begin
                if (in_char_reg == CH_NEWLINE)
                    mode_next = MODE_NORMAL;
            end
            MODE_BLOCK:
            begin
                if (in_char_reg == CH_STAR)
                    mode_next = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR:
            begin
                if (in_char_reg == CH_SLASH)
                    mode_next = MODE_NORMAL;
                else if (in_char_reg != CH_STAR)
                    mode_next = MODE_BLOCK;
            end
            MODE_QUOTE:
            begin
                if (in_char_reg == CH_BACKSLASH)
                    mode_next = MODE_QUOTE_ESC;
                else if (in_char_reg == (qkind_reg ? CH_SQUOTE : CH_DQUOTE))
                    mode_next = MODE_NORMAL;
            end
            MODE_QUOTE_ESC:
            begin
                mode_next = MODE_QUOTE;
            end
            default:
            begin
                code_byte = 1'b1;
            end
        endcase

        if (code_byte)
        begin
            mode_next = MODE_NORMAL;
            if (in_char_reg == CH_SLASH)
                mode_next = MODE_SLASH;
            else if (in_char_reg == CH_DQUOTE || in_char_reg == CH_SQUOTE)
            begin
                mode_next  = MODE_QUOTE;
                qkind_next = (in_char_reg == CH_SQUOTE);
            end
            else if (err_reg == ST_OK)
            begin
                case (in_char_reg)
                    CH_LBRACE:
                        if (brace_reg == COUNT_MAX) err_next = ST_OVERFLOW;
                        else brace_next = brace_reg + 1'b1;
                    CH_RBRACE:
                        if (brace_reg == '0) err_next = ST_EXTRA_BRACE;
                        else brace_next = brace_reg - 1'b1;
                    CH_LPAREN:
                        if (paren_reg == COUNT_MAX) err_next = ST_OVERFLOW;
                        else paren_next = paren_reg + 1'b1;
                    CH_RPAREN:
                        if (paren_reg == '0) err_next = ST_EXTRA_PAREN;
                        else paren_next = paren_reg - 1'b1;
                    CH_LBRACK:
                        if (brack_reg == COUNT_MAX) err_next = ST_OVERFLOW;
                        else brack_next = brack_reg + 1'b1;
                    CH_RBRACK:
                        if (brack_reg == '0) err_next = ST_EXTRA_BRACK;
                        else brack_next = brack_reg - 1'b1;
                    default: ;
                endcase
            end
        end

        status_next = err_next;
        if (in_last_reg && err_next == ST_OK)
        begin
            if (mode_next == MODE_BLOCK || mode_next == MODE_BLOCK_STAR)
                status_next = ST_OPEN_CMT;
            else if (brace_next != '0)
                status_next = ST_OPEN_BRACE;
            else if (paren_next != '0)
                status_next = ST_OPEN_PAREN;
            else if (brack_next != '0)
                status_next = ST_OPEN_BRACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_NORMAL;
            qkind_reg     <= 1'b0;
            brace_reg     <= '0;
            paren_reg     <= '0;
            brack_reg     <= '0;
            err_reg       <= ST_OK;
        end
        else
        begin
            if (req.ready)
                in_valid_reg <= req.valid;
            if (advance)
                out_valid_reg <= in_valid_reg;

            if (process)
            begin
                if (in_last_reg)
                begin
                    // verdict given, back to the reset condition
                    mode_reg  <= MODE_NORMAL;
                    qkind_reg <= 1'b0;
                    brace_reg <= '0;
                    paren_reg <= '0;
                    brack_reg <= '0;
                    err_reg   <= ST_OK;
                end
                else
                begin
                    mode_reg  <= mode_next;
                    qkind_reg <= qkind_next;
                    brace_reg <= brace_next;
                    paren_reg <= paren_next;
                    brack_reg <= brack_next;
                    err_reg   <= err_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_char_reg <= req.char_code;
            in_last_reg <= req.is_last;
        end
        if (process)
        begin
            out_status_reg <= status_next;
            out_final_reg  <= in_last_reg;
        end
    end

    // open codes only appear in a final verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_final_reg) |->
            (out_status_reg != ST_OPEN_CMT && out_status_reg != ST_OPEN_BRACE &&
             out_status_reg != ST_OPEN_PAREN && out_status_reg != ST_OPEN_BRACK))
    else $error("open status on a non-final result");

    // after the last byte is processed all state is back at reset
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && in_last_reg) |=>
            (mode_reg == MODE_NORMAL && brace_reg == '0 && paren_reg == '0 &&
             brack_reg == '0 && err_reg == ST_OK))
    else $error("state not cleared after last byte");

    // a latched error holds until the text ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !(process && in_last_reg)) |=> (err_reg == $past(err_reg)))
    else $error("latched error changed before end of text");

    // counts freeze once an error is latched
    assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ST_OK && !(process && in_last_reg)) |=>
            ($stable(brace_reg) && $stable(paren_reg) && $stable(brack_reg)))
    else $error("count moved after an error");

    // an empty output register never blocks the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> req.ready)
    else $error("input stalled with empty output register");

endmodule
